### rtl/cru_pkg.sv
package cru_pkg;

    localparam int unsigned CR_W      = 32;
    localparam int unsigned GPR_W     = 32;
    localparam int unsigned IMM_W     = 16;
    localparam int unsigned FIELD_W   = 3;
    localparam int unsigned BIT_W     = 5;
    localparam int unsigned MASK_W    = 8;
    localparam int unsigned XER_W     = 4;
    localparam int unsigned NIBBLE_W  = 4;
    localparam int unsigned S_DATA_W  = 120;
    localparam int unsigned M_DATA_W  = 72;

    // flag positions inside a 4-bit condition field
    localparam logic [NIBBLE_W-1:0] LT_FLAG = 4'h8;
    localparam logic [NIBBLE_W-1:0] GT_FLAG = 4'h4;
    localparam logic [NIBBLE_W-1:0] EQ_FLAG = 4'h2;
    localparam int unsigned         XER_SO_BIT = 3;

    typedef enum logic [3:0] {
        CMD_CMP   = 4'd0,
        CMD_CMPI  = 4'd1,
        CMD_CMPL  = 4'd2,
        CMD_CMPLI = 4'd3,
        CMD_AND   = 4'd4,
        CMD_ANDC  = 4'd5,
        CMD_EQV   = 4'd6,
        CMD_NAND  = 4'd7,
        CMD_NOR   = 4'd8,
        CMD_OR    = 4'd9,
        CMD_ORC   = 4'd10,
        CMD_XOR   = 4'd11,
        CMD_MCRF  = 4'd12,
        CMD_MCRXR = 4'd13,
        CMD_MFCR  = 4'd14,
        CMD_MTCRF = 4'd15
    } cmd_t;

    typedef struct packed {
        cmd_t               command;
        logic [GPR_W-1:0]   operand_a;
        logic [GPR_W-1:0]   operand_b;
        logic [IMM_W-1:0]   immediate;
        logic [FIELD_W-1:0] field_dest;
        logic [FIELD_W-1:0] field_src;
        logic [BIT_W-1:0]   bit_a;
        logic [BIT_W-1:0]   bit_b;
        logic [BIT_W-1:0]   bit_dest;
        logic [MASK_W-1:0]  field_mask;
        logic [XER_W-1:0]   xer_flags;
    } item_t;

    typedef struct packed {
        logic [CR_W-1:0]  cr_value;
        logic [GPR_W-1:0] gpr_value;
        logic             gpr_write;
        logic [XER_W-1:0] xer_flags_out;
    } result_t;

endpackage

### rtl/condition_register_unit.sv
// Condition register unit: executes one PowerPC CR instruction per item against
// the internal 32-bit condition register (reset to zero) and returns one result
// per item carrying the updated CR, the mfcr GPR value with its write flag, and
// the XER flags after the instruction. It takes one item every cycle unless a
// result stall holds it; an item passes the input and then the result register.
// The CR is updated as an item leaves the input register, so the following item
// always sees the result of the one before it. Result stalls back-pressure the
// input only once both registers are full.
module condition_register_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // operand_a, operand_b, immediate, field_dest, field_src, bit_a, bit_b,
    // bit_dest, field_mask, xer_flags, zero pad
    input  logic [cru_pkg::S_DATA_W-1:0]    s_tdata,
    // command
    input  logic [3:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cr_value, gpr_value, xer_flags_out, zero pad
    output logic [cru_pkg::M_DATA_W-1:0]    m_tdata,
    // gpr_write
    output logic                            m_tuser
);

    logic                        in_valid_reg;
    cru_pkg::item_t              in_item_reg;
    cru_pkg::item_t              in_item_next;
    logic                        out_valid_reg;
    cru_pkg::result_t            out_res_reg;
    cru_pkg::result_t            out_res_next;
    logic [cru_pkg::CR_W-1:0]    cr_reg;
    logic [cru_pkg::CR_W-1:0]    cr_next;
    logic                        advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_item_next.command    = cru_pkg::cmd_t'(s_tuser);
        in_item_next.operand_a  = s_tdata[31:0];
        in_item_next.operand_b  = s_tdata[63:32];
        in_item_next.immediate  = s_tdata[79:64];
        in_item_next.field_dest = s_tdata[82:80];
        in_item_next.field_src  = s_tdata[85:83];
        in_item_next.bit_a      = s_tdata[90:86];
        in_item_next.bit_b      = s_tdata[95:91];
        in_item_next.bit_dest   = s_tdata[100:96];
        in_item_next.field_mask = s_tdata[108:101];
        in_item_next.xer_flags  = s_tdata[112:109];
    end

    cru_exec u_exec (
        .cr_in  (cr_reg),
        .item   (in_item_reg),
        .cr_out (cr_next),
        .res    (out_res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cr_reg        <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (s_tvalid && s_tready) begin
                in_item_reg <= in_item_next;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg) begin
                out_res_reg <= out_res_next;
                cr_reg      <= cr_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.gpr_write;
    assign m_tdata  = {4'b0000, out_res_reg.xer_flags_out, out_res_reg.gpr_value,
                       out_res_reg.cr_value};

endmodule

### rtl/cru_exec.sv
module cru_exec (
    input  logic [cru_pkg::CR_W-1:0] cr_in,
    input  cru_pkg::item_t           item,
    output logic [cru_pkg::CR_W-1:0] cr_out,
    output cru_pkg::result_t         res
);

    logic [cru_pkg::GPR_W-1:0]    cmp_b;
    logic                         cmp_lt;
    logic                         cmp_gt;
    logic                         cmp_signed;
    logic [cru_pkg::NIBBLE_W-1:0] cmp_field;
    logic [cru_pkg::NIBBLE_W-1:0] src_field;
    logic [cru_pkg::BIT_W-1:0]    dest_pos;
    logic [cru_pkg::FIELD_W+1:0]  dest_shift;
    logic [cru_pkg::FIELD_W+1:0]  src_shift;
    logic [cru_pkg::CR_W-1:0]     mtcrf_mask;
    logic                         ba;
    logic                         bb;
    logic                         bd;

    // CR bit n lives at cr[31-n], field f at cr[(7-f)*4 +: 4]
    assign ba         = cr_in[~item.bit_a];
    assign bb         = cr_in[~item.bit_b];
    assign dest_pos   = ~item.bit_dest;
    assign dest_shift = {~item.field_dest, 2'b00};
    assign src_shift  = {~item.field_src, 2'b00};
    assign src_field  = cr_in[src_shift +: cru_pkg::NIBBLE_W];

    always_comb begin
        case (item.command)
            cru_pkg::CMD_CMPI: begin
                cmp_b = {{(cru_pkg::GPR_W-cru_pkg::IMM_W){item.immediate[cru_pkg::IMM_W-1]}},
                         item.immediate};
            end
            cru_pkg::CMD_CMPLI: begin
                cmp_b = {{(cru_pkg::GPR_W-cru_pkg::IMM_W){1'b0}}, item.immediate};
            end
            default: begin
                cmp_b = item.operand_b;
            end
        endcase
    end

    assign cmp_signed = (item.command == cru_pkg::CMD_CMP) ||
                        (item.command == cru_pkg::CMD_CMPI);
    assign cmp_lt = cmp_signed ? ($signed(item.operand_a) < $signed(cmp_b))
                               : (item.operand_a < cmp_b);
    assign cmp_gt = cmp_signed ? ($signed(item.operand_a) > $signed(cmp_b))
                               : (item.operand_a > cmp_b);

    always_comb begin
        if (cmp_lt) begin
            cmp_field = cru_pkg::LT_FLAG;
        end else if (cmp_gt) begin
            cmp_field = cru_pkg::GT_FLAG;
        end else begin
            cmp_field = cru_pkg::EQ_FLAG;
        end
        cmp_field[0] = item.xer_flags[cru_pkg::XER_SO_BIT];
    end

    always_comb begin
        for (int i = 0; i < cru_pkg::MASK_W; i++) begin
            mtcrf_mask[i*cru_pkg::NIBBLE_W +: cru_pkg::NIBBLE_W] =
                {cru_pkg::NIBBLE_W{item.field_mask[i]}};
        end
    end

    always_comb begin
        case (item.command)
            cru_pkg::CMD_AND:  bd = ba & bb;
            cru_pkg::CMD_ANDC: bd = ba & ~bb;
            cru_pkg::CMD_EQV:  bd = ~(ba ^ bb);
            cru_pkg::CMD_NAND: bd = ~(ba & bb);
            cru_pkg::CMD_NOR:  bd = ~(ba | bb);
            cru_pkg::CMD_OR:   bd = ba | bb;
            cru_pkg::CMD_ORC:  bd = ba | ~bb;
            default:           bd = ba ^ bb;
        endcase
    end

    always_comb begin
        cr_out            = cr_in;
        res.gpr_value     = '0;
        res.gpr_write     = 1'b0;
        res.xer_flags_out = item.xer_flags;
        case (item.command)
            cru_pkg::CMD_CMP, cru_pkg::CMD_CMPI, cru_pkg::CMD_CMPL, cru_pkg::CMD_CMPLI: begin
                cr_out[dest_shift +: cru_pkg::NIBBLE_W] = cmp_field;
            end
            cru_pkg::CMD_MCRF: begin
                cr_out[dest_shift +: cru_pkg::NIBBLE_W] = src_field;
            end
            cru_pkg::CMD_MCRXR: begin
                cr_out[dest_shift +: cru_pkg::NIBBLE_W] = item.xer_flags;
                res.xer_flags_out = '0;
            end
            cru_pkg::CMD_MFCR: begin
                res.gpr_value = cr_in;
                res.gpr_write = 1'b1;
            end
            cru_pkg::CMD_MTCRF: begin
                cr_out = (item.operand_a & mtcrf_mask) | (cr_in & ~mtcrf_mask);
            end
            default: begin
                cr_out[dest_pos] = bd;
            end
        endcase
        res.cr_value = cr_out;
    end

endmodule

### rtl/cru_checker.sv
module cru_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [cru_pkg::S_DATA_W-1:0] s_tdata,
    input logic [3:0]                   s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [cru_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tuser
);

    // mfcr returns the CR it leaves unchanged
    a_mfcr_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[63:32] == m_tdata[31:0])
        else $error("mfcr gpr value differs from cr value");

    a_gpr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[63:32] == 32'd0)
        else $error("gpr value nonzero without gpr write");

    // an item taken on an empty pipe passes the input register and then reaches the output
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid ##1 !m_tvalid |=> m_tvalid)
        else $error("item did not reach output");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind condition_register_unit cru_checker u_cru_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam logic [cru_pkg::NIBBLE_W-1:0] SO_FLAG   = 4'h1;
    localparam int                  IDLE_LIMIT = 1000;
    localparam int                  RANDOM_ITEMS = 1100;

    typedef struct {
        cru_pkg::item_t body;
        bit    drain_first;   // hold this item until every result is back
    } pending_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [cru_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [3:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [cru_pkg::M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    pending_t        instr_q[$];
    pending_t        head_item;
    cru_pkg::result_t cr_expect_q[$];
    cru_pkg::item_t  offered;
    logic [cru_pkg::CR_W-1:0] cr_shadow = '0;

    int  burst_left = 0;
    int  gap_left   = 0;
    int  results_seen = 0;
    int  stall_mode = 0;
    int  mode_left  = 0;
    int  hold_left  = 0;
    bit  held_once  = 1'b0;
    int  idle_cycles = 0;
    int  errors = 0;

    condition_register_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    // executes one CR instruction on the shadow register
    function automatic cru_pkg::result_t execute_cr(input cru_pkg::item_t it);
        cru_pkg::result_t r;
        logic [cru_pkg::GPR_W-1:0] a;
        logic [cru_pkg::GPR_W-1:0] b;
        logic [cru_pkg::CR_W-1:0]  mask;
        logic [cru_pkg::NIBBLE_W-1:0] nib;
        logic            ba;
        logic            bb;
        logic            d;
        int              dsh;
        int              ssh;
        r = '0;
        r.xer_flags_out = it.xer_flags;
        ba  = cr_shadow[31 - it.bit_a];
        bb  = cr_shadow[31 - it.bit_b];
        dsh = (7 - it.field_dest) * 4;
        ssh = (7 - it.field_src) * 4;
        case (it.command)
            cru_pkg::CMD_CMP, cru_pkg::CMD_CMPI, cru_pkg::CMD_CMPL, cru_pkg::CMD_CMPLI: begin
                a = it.operand_a;
                if (it.command == cru_pkg::CMD_CMPI)
                    b = {{16{it.immediate[15]}}, it.immediate};
                else if (it.command == cru_pkg::CMD_CMPLI)
                    b = {16'h0, it.immediate};
                else
                    b = it.operand_b;
                // signed order by flipping the sign bits
                if (it.command == cru_pkg::CMD_CMP || it.command == cru_pkg::CMD_CMPI) begin
                    a[31] = ~a[31];
                    b[31] = ~b[31];
                end
                nib = (a < b) ? cru_pkg::LT_FLAG :
                      (a > b) ? cru_pkg::GT_FLAG : cru_pkg::EQ_FLAG;
                if (it.xer_flags[cru_pkg::XER_SO_BIT])
                    nib = nib | SO_FLAG;
                cr_shadow[dsh +: 4] = nib;
            end
            cru_pkg::CMD_MCRF: begin
                nib = cr_shadow[ssh +: 4];
                cr_shadow[dsh +: 4] = nib;
            end
            cru_pkg::CMD_MCRXR: begin
                cr_shadow[dsh +: 4] = it.xer_flags;
                r.xer_flags_out = '0;
            end
            cru_pkg::CMD_MFCR: begin
                r.gpr_value = cr_shadow;
                r.gpr_write = 1'b1;
            end
            cru_pkg::CMD_MTCRF: begin
                mask = '0;
                for (int i = 0; i < 8; i++)
                    if (it.field_mask[i])
                        mask[i*4 +: 4] = 4'hf;
                cr_shadow = (it.operand_a & mask) | (cr_shadow & ~mask);
            end
            default: begin
                case (it.command)
                    cru_pkg::CMD_AND:  d = ba & bb;
                    cru_pkg::CMD_ANDC: d = ba & ~bb;
                    cru_pkg::CMD_EQV:  d = ~(ba ^ bb);
                    cru_pkg::CMD_NAND: d = ~(ba & bb);
                    cru_pkg::CMD_NOR:  d = ~(ba | bb);
                    cru_pkg::CMD_OR:   d = ba | bb;
                    cru_pkg::CMD_ORC:  d = ba | ~bb;
                    default:           d = ba ^ bb;
                endcase
                cr_shadow[31 - it.bit_dest] = d;
            end
        endcase
        r.cr_value = cr_shadow;
        return r;
    endfunction

    function automatic cru_pkg::item_t any_instr(input cru_pkg::cmd_t c);
        cru_pkg::item_t it;
        it.command    = c;
        it.operand_a  = $urandom;
        it.operand_b  = $urandom;
        it.immediate  = 16'($urandom);
        it.field_dest = 3'($urandom);
        it.field_src  = 3'($urandom);
        it.bit_a      = 5'($urandom);
        it.bit_b      = 5'($urandom);
        it.bit_dest   = 5'($urandom);
        it.field_mask = 8'($urandom);
        it.xer_flags  = 4'($urandom);
        return it;
    endfunction

    task automatic queue_instr(input cru_pkg::item_t it, input bit drain);
        pending_t p;
        p.body = it;
        p.drain_first = drain;
        instr_q.push_back(p);
    endtask

    // sender: bursts and gaps, item held until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                cr_expect_q.push_back(execute_cr(offered));
            if (s_tvalid && !s_tready) begin
                // keep offering the same item
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (instr_q.size() > 0 &&
                         !(instr_q[0].drain_first && cr_expect_q.size() != 0)) begin
                head_item = instr_q.pop_front();
                offered = head_item.body;
                s_tdata <= {7'b0, offered.xer_flags, offered.field_mask, offered.bit_dest,
                            offered.bit_b, offered.bit_a, offered.field_src,
                            offered.field_dest, offered.immediate, offered.operand_b,
                            offered.operand_a};
                s_tuser  <= offered.command;
                s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern changes every so often, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (results_seen >= 500 && !held_once) begin
                held_once = 1'b1;
                hold_left = 120;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(50, 200);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= (mode_left % 5) >= 2;
                    default: m_tready <= $urandom_range(0, 3) != 0;
                endcase
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        cru_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (cr_expect_q.size() == 0) begin
                $error("unexpected result item: cr_value %h", m_tdata[31:0]);
                errors++;
            end else begin
                want = cr_expect_q.pop_front();
                if (m_tdata[31:0] !== want.cr_value) begin
                    $error("cr_value: expected %h, got %h", want.cr_value, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== want.gpr_value) begin
                    $error("gpr_value: expected %h, got %h", want.gpr_value, m_tdata[63:32]);
                    errors++;
                end
                if (m_tuser !== want.gpr_write) begin
                    $error("gpr_write: expected %b, got %b", want.gpr_write, m_tuser);
                    errors++;
                end
                if (m_tdata[67:64] !== want.xer_flags_out) begin
                    $error("xer_flags_out: expected %h, got %h", want.xer_flags_out,
                           m_tdata[67:64]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        cru_pkg::item_t it;
        cru_pkg::cmd_t  c;

        it = any_instr(cru_pkg::CMD_MFCR);               queue_instr(it, 1'b0);
        it = any_instr(cru_pkg::CMD_CMP);
        it.operand_a = 32'h8000_0000; it.operand_b = 32'h7fff_ffff;
        it.field_dest = 3'd0; it.xer_flags = 4'h0;       queue_instr(it, 1'b0);
        it = any_instr(cru_pkg::CMD_CMPL);
        it.operand_a = 32'h8000_0000; it.operand_b = 32'h7fff_ffff;
        it.field_dest = 3'd1; it.xer_flags = 4'h8;       queue_instr(it, 1'b0);
        it = any_instr(cru_pkg::CMD_CMPI);
        it.operand_a = 32'hffff_ffff; it.immediate = 16'hffff;
        it.field_dest = 3'd2;                            queue_instr(it, 1'b0);
        it = any_instr(cru_pkg::CMD_CMPLI);
        it.operand_a = 32'hffff_ffff; it.immediate = 16'hffff;
        it.field_dest = 3'd3;                            queue_instr(it, 1'b0);
        it = any_instr(cru_pkg::CMD_CMPI);
        it.operand_a = 32'h8000_0000; it.immediate = 16'h8000;
        it.field_dest = 3'd6;                            queue_instr(it, 1'b0);
        it = any_instr(cru_pkg::CMD_CMP);
        it.operand_a = '0; it.operand_b = '0;
        it.field_dest = 3'd7; it.xer_flags = 4'h7;       queue_instr(it, 1'b0);
        it = any_instr(cru_pkg::CMD_MTCRF);
        it.operand_a = 32'ha5c3_96f0; it.field_mask = 8'hff;
        queue_instr(it, 1'b0);
        it = any_instr(cru_pkg::CMD_MTCRF);
        it.operand_a = 32'hffff_ffff; it.field_mask = 8'h81;
        queue_instr(it, 1'b0);
        it = any_instr(cru_pkg::CMD_MTCRF);
        it.operand_a = 32'hffff_ffff; it.field_mask = 8'h00;
        queue_instr(it, 1'b0);
        // one of each single-bit op, covering MSB and LSB positions
        for (int k = 0; k < 8; k++) begin
            c = cru_pkg::cmd_t'(cru_pkg::CMD_AND + k);
            it = any_instr(c);
            it.bit_a    = (k % 2) ? 5'd31 : 5'd0;
            it.bit_b    = (k % 3) ? 5'd0 : 5'd31;
            it.bit_dest = (k < 4) ? 5'd31 : 5'd0;
            queue_instr(it, 1'b0);
        end
        it = any_instr(cru_pkg::CMD_MCRF);
        it.field_dest = 3'd7; it.field_src = 3'd0;       queue_instr(it, 1'b0);
        it = any_instr(cru_pkg::CMD_MCRF);
        it.field_dest = 3'd0; it.field_src = 3'd7;       queue_instr(it, 1'b0);
        // reserved XER bit is copied as given
        it = any_instr(cru_pkg::CMD_MCRXR);
        it.field_dest = 3'd4; it.xer_flags = 4'hf;       queue_instr(it, 1'b0);
        it = any_instr(cru_pkg::CMD_MCRXR);
        it.field_dest = 3'd5; it.xer_flags = 4'h1;       queue_instr(it, 1'b0);
        it = any_instr(cru_pkg::CMD_MFCR);               queue_instr(it, 1'b0);
        it = any_instr(cru_pkg::CMD_MTCRF);
        it.operand_a = 32'h1234_5678; it.field_mask = 8'h18;
        queue_instr(it, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            it = any_instr(cru_pkg::cmd_t'($urandom_range(0, 15)));
            queue_instr(it, n == 300 || n == 800 || $urandom_range(0, 99) == 0);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (instr_q.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (cr_expect_q.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
